>>> rtl/core/rrs_pkg.sv
package rrs_pkg;

  // Task slots on the ring
  localparam int unsigned NumTasks = 32;
  localparam int unsigned IdxW     = $clog2(NumTasks);
  localparam int unsigned CntW     = $clog2(NumTasks + 1);

  // Field widths
  localparam int unsigned TaskW  = 5;
  localparam int unsigned StateW = 3;

  localparam logic [StateW-1:0] StRunning = 3'd0;
  localparam logic [StateW-1:0] StBlocked = 3'd2;

  typedef enum logic [1:0] {
    OpWake   = 2'd0,
    OpSched  = 2'd1,
    OpEnable = 2'd2
  } op_e;

  typedef struct packed {
    op_e               op;
    logic [TaskW-1:0]  task_id;
    logic [StateW-1:0] target_state;
    logic              again;
    logic              delayed;
    logic signed [7:0] reason;
    logic              enable_value;
  } item_t;

  typedef struct packed {
    logic             switched;
    logic [TaskW-1:0] next_task;
    logic             next_is_idle;
    logic             status;
  } result_t;

endpackage

>>> rtl/core/round_robin_run_queue_scheduler.sv
// Channel   Dir  Handshake                  Payload
// in        in   in_valid_i / in_stall_o    opcode, task_id, target_state, again,
//                                           delayed, reason, enable_value
// out       out  out_valid_o / out_stall_i  switched, next_task, next_is_idle, status
// cfg       in   cfg_valid_i / cfg_ready_o  cfg_data_i = idle_task
//
// Path: input register, then ring update and result register.
// One request per cycle while the result side does not stall; the ring, link
// and state updates for a request all settle in the cycle between the two registers.
// Reset (async, active low) empties the ring, blocks all tasks, disables
// scheduling; link tables have no reset and are rewritten on insertion.
// A stalled result holds the input register; in_stall_o rises only then.
module round_robin_run_queue_scheduler (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [1:0]                    in_opcode_i,
  input  logic [rrs_pkg::TaskW-1:0]     in_task_id_i,
  input  logic [rrs_pkg::StateW-1:0]    in_target_state_i,
  input  logic                          in_again_i,
  input  logic                          in_delayed_i,
  input  logic signed [7:0]             in_reason_i,
  input  logic                          in_enable_value_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic                          out_switched_o,
  output logic [rrs_pkg::TaskW-1:0]     out_next_task_o,
  output logic                          out_next_is_idle_o,
  output logic                          out_status_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [rrs_pkg::TaskW-1:0]     cfg_data_i
);
  import rrs_pkg::*;

  logic             s1_vld_q, s1_vld_d;
  item_t            s1_item_q, in_item;
  logic             in_acc, adv;
  logic             out_full;
  logic [TaskW-1:0] idle_task_q;
  result_t          ring_res, out_res;

  assign in_item.op           = op_e'(in_opcode_i);
  assign in_item.task_id      = in_task_id_i;
  assign in_item.target_state = in_target_state_i;
  assign in_item.again        = in_again_i;
  assign in_item.delayed      = in_delayed_i;
  assign in_item.reason       = in_reason_i;
  assign in_item.enable_value = in_enable_value_i;

  // request moves to the result register when that register frees up
  assign adv        = s1_vld_q & ~(out_full & out_stall_i);
  assign in_stall_o = s1_vld_q & ~adv;
  assign in_acc     = in_valid_i & ~in_stall_o;
  assign s1_vld_d   = in_acc | (s1_vld_q & ~adv);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
    end else begin
      s1_vld_q <= s1_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_item_q <= in_item;
    end
  end

  // idle task register; the user must write it only while no request is in flight (unchecked by the block)
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idle_task_q <= '0;
    end else if (cfg_valid_i) begin
      idle_task_q <= cfg_data_i;
    end
  end

  rrs_ring u_ring (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .fire_i      (adv),
    .item_i      (s1_item_q),
    .idle_task_i (idle_task_q),
    .res_o       (ring_res)
  );

  rrs_out_reg u_out (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .load_i (adv),
    .res_i  (ring_res),
    .full_o (out_full),
    .res_o  (out_res),
    .take_i (~out_stall_i)
  );

  assign out_valid_o        = out_full;
  assign out_switched_o     = out_res.switched;
  assign out_next_task_o    = out_res.next_task;
  assign out_next_is_idle_o = out_res.next_is_idle;
  assign out_status_o       = out_res.status;

endmodule

>>> rtl/core/rrs_ring.sv
module rrs_ring (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          fire_i,
  input  rrs_pkg::item_t                item_i,
  input  logic [rrs_pkg::TaskW-1:0]     idle_task_i,
  output rrs_pkg::result_t              res_o
);
  import rrs_pkg::*;

  // ring links, no reset: only links of queued slots are read
  logic [IdxW-1:0]   nl_q [NumTasks];
  logic [IdxW-1:0]   nl_d [NumTasks];
  logic [IdxW-1:0]   pl_q [NumTasks];
  logic [IdxW-1:0]   pl_d [NumTasks];
  logic [StateW-1:0] ts_q [NumTasks];
  logic [StateW-1:0] ts_d [NumTasks];
  logic [NumTasks-1:0] qd_q, qd_d;
  logic [IdxW-1:0]   head_q, head_d;
  logic [CntW-1:0]   cnt_q, cnt_d;
  logic              en_q, en_d;
  logic              pend_q, pend_d;

  logic [IdxW-1:0]   tix, n_ix, p_ix, h_ix, hp_ix;
  logic              sched;
  rrs_pkg::result_t  res;

  assign tix = item_i.task_id[IdxW-1:0];

  always_comb begin
    nl_d   = nl_q;
    pl_d   = pl_q;
    ts_d   = ts_q;
    qd_d   = qd_q;
    head_d = head_q;
    cnt_d  = cnt_q;
    en_d   = en_q;
    pend_d = pend_q;
    n_ix   = '0;
    p_ix   = '0;
    h_ix   = '0;
    hp_ix  = '0;
    sched  = 1'b0;
    res    = '0;

    case (item_i.op)
      OpWake: begin
        if (32'(item_i.task_id) < NumTasks) begin
          if (ts_q[tix] == item_i.target_state && !item_i.again) begin
            res.status = 1'b1;
          end else begin
            // take the slot off the ring first (also covers a repeat wake)
            if (qd_d[tix] && cnt_d != '0) begin
              qd_d[tix] = 1'b0;
              if (cnt_d == CntW'(1)) begin
                cnt_d = '0;
              end else begin
                n_ix       = nl_d[tix];
                p_ix       = pl_d[tix];
                nl_d[p_ix] = n_ix;
                pl_d[n_ix] = p_ix;
                if (head_d == tix) begin
                  head_d = n_ix;
                end
                cnt_d = cnt_d - CntW'(1);
              end
            end
            if (item_i.target_state == StRunning) begin
              if (cnt_d == '0) begin
                nl_d[tix] = tix;
                pl_d[tix] = tix;
                head_d    = tix;
              end else begin
                h_ix        = head_d;
                hp_ix       = pl_d[h_ix];
                nl_d[hp_ix] = tix;
                pl_d[tix]   = hp_ix;
                nl_d[tix]   = h_ix;
                pl_d[h_ix]  = tix;
                if (item_i.reason > 8'sd0) begin
                  head_d = tix;
                end
              end
              qd_d[tix] = 1'b1;
              cnt_d     = cnt_d + CntW'(1);
              ts_d[tix] = StRunning;
              sched     = !item_i.delayed;
            end else begin
              ts_d[tix] = item_i.target_state;
            end
          end
        end
      end
      OpSched: begin
        sched = 1'b1;
      end
      OpEnable: begin
        en_d  = item_i.enable_value;
        sched = item_i.enable_value && pend_q;
      end
      default: begin
      end
    endcase

    if (sched) begin
      if (!en_d) begin
        pend_d = 1'b1;
      end else begin
        pend_d       = 1'b0;
        res.switched = 1'b1;
        if (cnt_d == '0) begin
          res.next_task    = idle_task_i;
          res.next_is_idle = 1'b1;
        end else begin
          head_d        = nl_d[head_d];
          res.next_task = TaskW'(head_d);
        end
      end
    end
  end

  assign res_o = res;

  always_ff @(posedge clk_i) begin
    if (fire_i) begin
      nl_q <= nl_d;
      pl_q <= pl_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ts_q   <= '{default: StBlocked};
      qd_q   <= '0;
      head_q <= '0;
      cnt_q  <= '0;
      en_q   <= 1'b0;
      pend_q <= 1'b0;
    end else if (fire_i) begin
      ts_q   <= ts_d;
      qd_q   <= qd_d;
      head_q <= head_d;
      cnt_q  <= cnt_d;
      en_q   <= en_d;
      pend_q <= pend_d;
    end
  end

  // ring size tracks the queued flags
  a_cnt_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(qd_q) == int'(cnt_q))
    else $error("ring count differs from queued flags");

  // a pending schedule never survives while enabled
  a_pend_en: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(pend_q && en_q))
    else $error("pending schedule left while enabled");

  // a refused wake leaves the ring alone
  a_refused: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire_i && res.status |=> $stable(cnt_q) && $stable(qd_q) && $stable(head_q))
    else $error("refused wake changed the ring");

endmodule

>>> rtl/core/rrs_out_reg.sv
module rrs_out_reg (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             load_i,
  input  rrs_pkg::result_t res_i,
  output logic             full_o,
  output rrs_pkg::result_t res_o,
  input  logic             take_i
);
  import rrs_pkg::*;

  logic    vld_q, vld_d;
  result_t res_q;

  assign vld_d = load_i | (vld_q & ~take_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

  assign full_o = vld_q;
  assign res_o  = res_q;

endmodule

>>> tb/sv/testbench.sv
module testbench;
  import rrs_pkg::*;

  // Opcode 3 has no meaning in the block; it must answer with an all-zero result.
  localparam logic [1:0] OpUnused = 2'd3;
  // Cycles with no handshake on any channel before the run is declared hung.
  localparam int unsigned HangLimit = 3000;
  localparam int unsigned PhaseRequests = 235;
  localparam int unsigned NumPhases = 8;

  localparam result_t NoRes   = '0;
  localparam result_t Refused = '{switched: 1'b0, next_task: '0, next_is_idle: 1'b0,
                                  status: 1'b1};
  // Idle task is set to 31 before the directed rows run.
  localparam result_t IdleHi  = '{switched: 1'b1, next_task: 5'd31, next_is_idle: 1'b1,
                                  status: 1'b0};

  // One directed request; when pinned is set, res is the answer read off by hand,
  // otherwise the answer comes from the run-queue mirror.
  typedef struct packed {
    logic [1:0]        op;
    logic [TaskW-1:0]  tid;
    logic [StateW-1:0] st;
    logic              again;
    logic              delayed;
    logic signed [7:0] rsn;
    logic              en;
    logic              pinned;
    result_t           res;
  } dir_row_t;

  localparam int unsigned NumDirRows = 24;
  localparam dir_row_t DirRows [NumDirRows] = '{
    // schedule while disabled: only pending is set
    '{OpSched,  5'd0,  3'd0, 1'b0, 1'b0, 8'h00, 1'b0, 1'b1, NoRes},
    // enable with pending: empty ring, so the idle task runs
    '{OpEnable, 5'd0,  3'd0, 1'b0, 1'b0, 8'h00, 1'b1, 1'b1, IdleHi},
    // every task starts blocked (2), so this wake is refused
    '{OpWake,   5'd2,  3'd2, 1'b0, 1'b0, 8'h00, 1'b0, 1'b1, Refused},
    // first runnable task, largest positive reason, schedules right away
    '{OpWake,   5'd0,  3'd0, 1'b0, 1'b0, 8'h7f, 1'b0, 1'b0, NoRes},
    // most negative reason goes to the tail, delayed: no schedule
    '{OpWake,   5'd31, 3'd0, 1'b0, 1'b1, 8'h80, 1'b0, 1'b0, NoRes},
    // zero reason is not positive: tail
    '{OpWake,   5'd5,  3'd0, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0, NoRes},
    // smallest positive reason: head
    '{OpWake,   5'd7,  3'd0, 1'b0, 1'b1, 8'h01, 1'b0, 1'b0, NoRes},
    // wake again while queued: unlinked, then put back at the head
    '{OpWake,   5'd5,  3'd0, 1'b1, 1'b1, 8'h64, 1'b0, 1'b0, NoRes},
    // same state without again: refused
    '{OpWake,   5'd5,  3'd0, 1'b0, 1'b0, 8'h10, 1'b0, 1'b1, Refused},
    // leaving running takes the task off the ring
    '{OpWake,   5'd31, 3'd1, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0, NoRes},
    '{OpWake,   5'd0,  3'd7, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0, NoRes},
    '{OpSched,  5'd0,  3'd0, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0, NoRes},
    // disable without pending, schedule while disabled, disable with pending
    '{OpEnable, 5'd0,  3'd0, 1'b0, 1'b0, 8'h00, 1'b0, 1'b1, NoRes},
    '{OpSched,  5'd0,  3'd0, 1'b0, 1'b0, 8'h00, 1'b0, 1'b1, NoRes},
    '{OpEnable, 5'd0,  3'd0, 1'b0, 1'b0, 8'h00, 1'b0, 1'b1, NoRes},
    // enable with pending: the held schedule fires
    '{OpEnable, 5'd0,  3'd0, 1'b0, 1'b0, 8'h00, 1'b1, 1'b0, NoRes},
    // unused opcode with every payload bit set
    '{OpUnused, 5'd31, 3'd7, 1'b1, 1'b1, 8'hff, 1'b1, 1'b1, NoRes},
    // enable without pending: nothing happens
    '{OpEnable, 5'd0,  3'd0, 1'b0, 1'b0, 8'h00, 1'b1, 1'b1, NoRes},
    // drain the ring, then schedule onto the idle task
    '{OpWake,   5'd7,  3'd3, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0, NoRes},
    '{OpWake,   5'd5,  3'd4, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0, NoRes},
    '{OpSched,  5'd0,  3'd0, 1'b0, 1'b0, 8'h00, 1'b0, 1'b1, IdleHi},
    // again on a blocked task that is not queued
    '{OpWake,   5'd5,  3'd4, 1'b1, 1'b0, 8'h00, 1'b0, 1'b0, NoRes},
    // exited task comes back as the only one on the ring
    '{OpWake,   5'd31, 3'd0, 1'b0, 1'b0, 8'h7f, 1'b0, 1'b0, NoRes},
    '{OpWake,   5'd31, 3'd6, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0, NoRes}
  };

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              in_valid_i = 1'b0;
  logic              in_stall_o;
  logic [1:0]        in_opcode_i = '0;
  logic [TaskW-1:0]  in_task_id_i = '0;
  logic [StateW-1:0] in_target_state_i = '0;
  logic              in_again_i = 1'b0;
  logic              in_delayed_i = 1'b0;
  logic signed [7:0] in_reason_i = '0;
  logic              in_enable_value_i = 1'b0;
  logic              out_valid_o;
  logic              out_stall_i = 1'b0;
  logic              out_switched_o;
  logic [TaskW-1:0]  out_next_task_o;
  logic              out_next_is_idle_o;
  logic              out_status_o;
  logic              cfg_valid_i = 1'b0;
  logic              cfg_ready_o;
  logic [TaskW-1:0]  cfg_data_i = '0;

  // Travels with each request: pinned answer for directed rows.
  logic              req_pinned = 1'b0;
  result_t           req_res = '0;

  // Idling knobs, percent per cycle; changed only while the block is drained.
  int unsigned       src_gap_pct = 0;
  int unsigned       sink_stall_pct = 0;

  round_robin_run_queue_scheduler dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_stall_o        (in_stall_o),
    .in_opcode_i       (in_opcode_i),
    .in_task_id_i      (in_task_id_i),
    .in_target_state_i (in_target_state_i),
    .in_again_i        (in_again_i),
    .in_delayed_i      (in_delayed_i),
    .in_reason_i       (in_reason_i),
    .in_enable_value_i (in_enable_value_i),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .out_switched_o    (out_switched_o),
    .out_next_task_o   (out_next_task_o),
    .out_next_is_idle_o(out_next_is_idle_o),
    .out_status_o      (out_status_o),
    .cfg_valid_i       (cfg_valid_i),
    .cfg_ready_o       (cfg_ready_o),
    .cfg_data_i        (cfg_data_i)
  );

  always #5 clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // Run-queue mirror: ring links, per-task state, enable/pending, idle slot.
  // Links are only read for slots that are on the ring.
  // ---------------------------------------------------------------------------
  logic [TaskW-1:0]  rq_next [NumTasks];
  logic [TaskW-1:0]  rq_prev [NumTasks];
  logic              rq_on   [NumTasks];
  logic [TaskW-1:0]  rq_head;
  int unsigned       rq_cnt;
  logic [StateW-1:0] tsk_state  [NumTasks];
  logic [7:0]        tsk_reason [NumTasks];
  logic              sch_en;
  logic              sch_pend;
  logic [TaskW-1:0]  idle_slot;

  result_t           sched_due [$];  // answers still owed by the block

  function automatic void mirror_reset();
    for (int i = 0; i < NumTasks; i++) begin
      rq_next[i]    = '0;
      rq_prev[i]    = '0;
      rq_on[i]      = 1'b0;
      tsk_state[i]  = StBlocked;
      tsk_reason[i] = '0;
    end
    rq_head   = '0;
    rq_cnt    = 0;
    sch_en    = 1'b0;
    sch_pend  = 1'b0;
    idle_slot = '0;
  endfunction

  function automatic void ring_drop(input logic [TaskW-1:0] t);
    logic [TaskW-1:0] n;
    logic [TaskW-1:0] p;
    if (!rq_on[t] || rq_cnt == 0) return;
    rq_on[t] = 1'b0;
    if (rq_cnt == 1) begin
      rq_cnt = 0;
      return;
    end
    n = rq_next[t];
    p = rq_prev[t];
    rq_next[p] = n;
    rq_prev[n] = p;
    if (rq_head == t) rq_head = n;
    rq_cnt--;
  endfunction

  function automatic void ring_add(input logic [TaskW-1:0] t, input logic at_head);
    logic [TaskW-1:0] p;
    if (rq_cnt == 0) begin
      rq_next[t] = t;
      rq_prev[t] = t;
      rq_head    = t;
    end else begin
      p = rq_prev[rq_head];
      rq_next[p]       = t;
      rq_prev[t]       = p;
      rq_next[t]       = rq_head;
      rq_prev[rq_head] = t;
      if (at_head) rq_head = t;
    end
    rq_on[t] = 1'b1;
    rq_cnt++;
  endfunction

  // Rotate and pick, or just remember the schedule while disabled.
  function automatic result_t run_pick();
    result_t r;
    r = '0;
    if (!sch_en) begin
      sch_pend = 1'b1;
    end else begin
      sch_pend   = 1'b0;
      r.switched = 1'b1;
      if (rq_cnt == 0) begin
        r.next_task    = idle_slot;
        r.next_is_idle = 1'b1;
      end else begin
        rq_head     = rq_next[rq_head];
        r.next_task = rq_head;
      end
    end
    return r;
  endfunction

  function automatic result_t sched_predict(input logic [1:0] op,
                                            input logic [TaskW-1:0] t,
                                            input logic [StateW-1:0] st,
                                            input logic again,
                                            input logic delayed,
                                            input logic [7:0] rsn,
                                            input logic en);
    result_t r;
    logic    to_head;
    r = '0;
    case (op)
      OpWake: begin
        if (tsk_state[t] == st && !again) begin
          r.status = 1'b1;
        end else if (st == StRunning) begin
          // strictly positive reason jumps the queue
          to_head = !rsn[7] && rsn != 8'd0;
          ring_drop(t);
          ring_add(t, to_head);
          tsk_state[t]  = StRunning;
          tsk_reason[t] = rsn;
          if (!delayed) r = run_pick();
        end else begin
          ring_drop(t);
          tsk_state[t] = st;
        end
      end
      OpSched: begin
        r = run_pick();
      end
      OpEnable: begin
        sch_en = en;
        if (en && sch_pend) r = run_pick();
      end
      default: begin
      end
    endcase
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Monitor: predicts at request acceptance, checks at result acceptance.
  // Everything is sampled at the rising edge; the drivers only use NBAs there.
  // ---------------------------------------------------------------------------
  int unsigned n_req = 0;
  int unsigned n_res = 0;
  int unsigned n_switch = 0;
  int unsigned n_idle_pick = 0;
  int unsigned n_refused = 0;
  int unsigned n_err = 0;
  int unsigned quiet_cycles = 0;

  always @(posedge clk_i) begin
    result_t pred;
    result_t got;
    result_t want;
    if (rst_ni) begin
      if (cfg_valid_i && cfg_ready_o) idle_slot = cfg_data_i;

      if (in_valid_i && !in_stall_o) begin
        pred = sched_predict(in_opcode_i, in_task_id_i, in_target_state_i, in_again_i,
                             in_delayed_i, in_reason_i, in_enable_value_i);
        sched_due.push_back(req_pinned ? req_res : pred);
        n_req++;
      end

      if (out_valid_o && !out_stall_i) begin
        got = '{switched: out_switched_o, next_task: out_next_task_o,
                next_is_idle: out_next_is_idle_o, status: out_status_o};
        n_res++;
        if (got.switched) n_switch++;
        if (got.next_is_idle) n_idle_pick++;
        if (got.status) n_refused++;
        if (sched_due.size() == 0) begin
          n_err++;
          if (n_err <= 10)
            $display("ERROR: unexpected result sw=%0d task=%0d idle=%0d status=%0d",
                     got.switched, got.next_task, got.next_is_idle, got.status);
        end else begin
          want = sched_due.pop_front();
          if (got.switched !== want.switched || got.next_task !== want.next_task ||
              got.next_is_idle !== want.next_is_idle || got.status !== want.status) begin
            n_err++;
            if (n_err <= 10)
              $display("ERROR: result %0d: expected sw=%0d task=%0d idle=%0d status=%0d,",
                       n_res, want.switched, want.next_task, want.next_is_idle,
                       want.status, " got sw=%0d task=%0d idle=%0d status=%0d",
                       got.switched, got.next_task, got.next_is_idle, got.status);
          end
        end
      end
    end
  end

  // Hang detector: any handshake resets the count.
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles + 1 >= HangLimit) begin
      $display("ERROR: no progress for %0d cycles, %0d results outstanding",
               HangLimit, sched_due.size());
      $display("*** FAILED ***");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Result side back-pressure.
  always @(posedge clk_i) begin
    out_stall_i <= (sink_stall_pct != 0) && ($urandom_range(99) < sink_stall_pct);
  end

  // ---------------------------------------------------------------------------
  // Drivers
  // ---------------------------------------------------------------------------
  task automatic send_request(input logic [1:0] op, input logic [TaskW-1:0] t,
                              input logic [StateW-1:0] st, input logic again,
                              input logic delayed, input logic [7:0] rsn,
                              input logic en, input logic pinned, input result_t res);
    // random source gaps before the request goes up
    while (src_gap_pct != 0 && $urandom_range(99) < src_gap_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i        <= 1'b1;
    in_opcode_i       <= op;
    in_task_id_i      <= t;
    in_target_state_i <= st;
    in_again_i        <= again;
    in_delayed_i      <= delayed;
    in_reason_i       <= rsn;
    in_enable_value_i <= en;
    req_pinned        <= pinned;
    req_res           <= res;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  // Mostly wakes and schedules, some enables, random content; a few unused opcodes.
  // A narrow task pool keeps the ring short so it empties often.
  task automatic random_request(input logic narrow);
    int unsigned      pick;
    logic [1:0]       op;
    logic [TaskW-1:0] t;
    logic [StateW-1:0] st;
    logic [7:0]       rsn;
    logic             en;
    pick = $urandom_range(99);
    if (pick < 50)      op = OpWake;
    else if (pick < 78) op = OpSched;
    else if (pick < 95) op = OpEnable;
    else                op = OpUnused;
    if (narrow) t = $urandom_range(1) ? TaskW'($urandom_range(3, 0))
                                      : TaskW'($urandom_range(31, 28));
    else        t = TaskW'($urandom_range(31, 0));
    st  = ($urandom_range(99) < 55) ? StRunning : StateW'($urandom_range(7, 1));
    rsn = ($urandom_range(9) == 0) ? 8'd0 : 8'($urandom_range(255));
    en  = (op == OpEnable) ? ($urandom_range(99) < 70) : 1'($urandom_range(1));
    send_request(op, t, st, $urandom_range(99) < 25, 1'($urandom_range(1)), rsn, en,
                 1'b0, NoRes);
  endtask

  task automatic write_idle_task(input logic [TaskW-1:0] slot);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= slot;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
  endtask

  // Source holds off until every owed result is back, then idles a while longer.
  task automatic drain_results();
    in_valid_i <= 1'b0;
    while (sched_due.size() != 0) @(posedge clk_i);
    repeat (3) @(posedge clk_i);
  endtask

  initial begin
    dir_row_t row;
    logic [TaskW-1:0] idle_pick;
    mirror_reset();
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed rows, no idling on either side
    write_idle_task(5'd31);
    for (int i = 0; i < NumDirRows; i++) begin
      row = DirRows[i];
      send_request(row.op, row.tid, row.st, row.again, row.delayed, row.rsn, row.en,
                   row.pinned, row.res);
    end
    drain_results();

    // random phases: idling modes cycle none, source, sink, both
    for (int p = 0; p < NumPhases; p++) begin
      case (p % 4)
        0: begin src_gap_pct = 0;  sink_stall_pct = 0;  end
        1: begin src_gap_pct = 46; sink_stall_pct = 0;  end
        2: begin src_gap_pct = 0;  sink_stall_pct = 46; end
        default: begin src_gap_pct = 35; sink_stall_pct = 35; end
      endcase
      if (p == 0)                  idle_pick = '0;
      else if (p == NumPhases - 1) idle_pick = '1;
      else                         idle_pick = TaskW'($urandom_range(31));
      write_idle_task(idle_pick);
      for (int k = 0; k < PhaseRequests; k++) random_request(p % 3 == 2);
      drain_results();
    end

    sink_stall_pct = 0;
    repeat (10) @(posedge clk_i);
    $display("Run covered %0d requests over %0d idling phases: %0d task switches",
             n_req, NumPhases, n_switch);
    $display("  of which %0d picked the idle task, and %0d refused wakes",
             n_idle_pick, n_refused);
    if (n_err == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("%0d mismatching results", n_err);
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

>>> sim.f
rtl/core/rrs_pkg.sv
rtl/core/rrs_ring.sv
rtl/core/rrs_out_reg.sv
rtl/core/round_robin_run_queue_scheduler.sv
tb/sv/testbench.sv
